// ===== rtl/core/grc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and command codes for the grid ray caster core.
// Used by every module under rtl/core except grc_ram; no dependencies of its own.
package grc_pkg;

	localparam int MAP_SIZE    = 32;
	localparam int MAP_BITS    = $clog2(MAP_SIZE);
	localparam int MAP_DEPTH   = MAP_SIZE * MAP_SIZE;
	localparam int ADDR_W      = 2 * MAP_BITS;
	localparam int CELL_W      = 3;
	localparam int MAX_STEPS   = 100;
	localparam int STEP_W      = $clog2(MAX_STEPS + 1);
	localparam int TEX_SIZE    = 64;
	localparam int TEX_W       = $clog2(TEX_SIZE);
	localparam int MAX_COLUMNS = 1024;

	localparam int POS_W  = 21;
	localparam int VEC_W  = 18;
	localparam int SCR_W  = 11;
	localparam int COL_W  = 10;
	localparam int CFG_W  = 21;
	localparam int IDX_W  = 4;

	localparam int CAM_W   = 29;
	localparam int RAY_W   = 30;
	localparam int DEN_W   = 29;
	localparam int NUM_W   = 33;
	localparam int DELTA_W = 41;
	localparam int SD_W    = 48;
	localparam int PERP_W  = 24;
	localparam int MUL_W   = 31;
	localparam int PROD_W  = 62;
	localparam int CRD_W   = $clog2(MAP_SIZE + MAX_STEPS) + 2;
	localparam int HGT_W   = 11;
	localparam int SPAN_W  = 10;

	localparam logic [DELTA_W-1:0] DELTA_INF = DELTA_W'(1) << 40;

	// register indices
	localparam logic [IDX_W-1:0] REG_POS_X    = 4'd0;
	localparam logic [IDX_W-1:0] REG_POS_Y    = 4'd1;
	localparam logic [IDX_W-1:0] REG_DIR_X    = 4'd2;
	localparam logic [IDX_W-1:0] REG_DIR_Y    = 4'd3;
	localparam logic [IDX_W-1:0] REG_PLANE_X  = 4'd4;
	localparam logic [IDX_W-1:0] REG_PLANE_Y  = 4'd5;
	localparam logic [IDX_W-1:0] REG_SCREEN_W = 4'd6;
	localparam logic [IDX_W-1:0] REG_SCREEN_H = 4'd7;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [VEC_W-1:0] dir_x;
		logic [VEC_W-1:0] dir_y;
		logic [VEC_W-1:0] plane_x;
		logic [VEC_W-1:0] plane_y;
		logic [SCR_W-1:0] screen_width;
		logic [SCR_W-1:0] screen_height;
	} cfg_t;

	typedef logic [4:0] op_t;
	localparam op_t OP_NOP    = 5'd0;
	localparam op_t OP_CLEAR  = 5'd1;
	localparam op_t OP_MAPWR  = 5'd2;
	localparam op_t OP_INIT   = 5'd3;
	localparam op_t OP_CAM    = 5'd4;
	localparam op_t OP_MULX   = 5'd5;
	localparam op_t OP_MULY   = 5'd6;
	localparam op_t OP_RDY    = 5'd7;
	localparam op_t OP_DX     = 5'd8;
	localparam op_t OP_DY     = 5'd9;
	localparam op_t OP_SX_LO  = 5'd10;
	localparam op_t OP_SX_HI  = 5'd11;
	localparam op_t OP_SY_LO  = 5'd12;
	localparam op_t OP_SY_HI  = 5'd13;
	localparam op_t OP_SY_END = 5'd14;
	localparam op_t OP_STEP   = 5'd15;
	localparam op_t OP_CHECK  = 5'd16;
	localparam op_t OP_PERP   = 5'd17;
	localparam op_t OP_TEX    = 5'd18;
	localparam op_t OP_FINISH = 5'd19;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic stop;
		logic clr_last;
	} sts_t;

endpackage

// ===== rtl/core/grid_ray_caster_column_core.sv =====
`timescale 1ns / 1ps
// Top level of the grid ray caster: configuration registers, sequencer, datapath.
// Depends on grc_pkg, grc_ctrl, grc_dp (and through it grc_div, grc_ram).

// One ray per screen column through a 32x32 map of 3-bit cell codes, DDA stepping.
// After reset the block clears the map, one cell a cycle, with busy high until the
// last cell is cleared. A beat is taken when start is high and busy low. A map-write
// beat (req_type 1) is stored at that edge and never raises busy, so writes stream one
// per cycle. A cast beat raises busy and gives one result, shown for exactly one
// cycle with done high; the receiver must take it then, there is no hold-off.
// While busy, a cast takes n DDA steps (1..100) and four divisions, which run on one
// shared bit-serial divider (camera value, two inverse ray components, slice height);
// each DDA step has a step state and a check state because the map read is registered.
// Outside-map cells count as walls with code 1; a zero distance gives height 2047.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while idle;
// the block does not enforce this.
module grid_ray_caster_column_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [grc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [grc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [grc_pkg::COL_W-1:0]    column,
	input  logic [grc_pkg::MAP_BITS-1:0] cell_row,
	input  logic [grc_pkg::MAP_BITS-1:0] cell_col,
	input  logic [grc_pkg::CELL_W-1:0]   cell_value,
	output logic                         done,
	output logic                         wall_found,
	output logic                         hit_side,
	output logic [grc_pkg::MAP_BITS-1:0] hit_row,
	output logic [grc_pkg::MAP_BITS-1:0] hit_col,
	output logic [2:0]                   texture_index,
	output logic [grc_pkg::PERP_W-1:0]   perp_distance,
	output logic [grc_pkg::HGT_W-1:0]    slice_height,
	output logic [grc_pkg::SPAN_W-1:0]   draw_start,
	output logic [grc_pkg::SPAN_W-1:0]   draw_end,
	output logic [grc_pkg::TEX_W-1:0]    texture_column
);

	grc_pkg::cfg_t cfg_q;
	grc_pkg::cmd_t cmd;
	grc_pkg::sts_t sts;

	// camera and screen registers; unknown indices are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x         <= '0;
			cfg_q.pos_y         <= '0;
			cfg_q.dir_x         <= 18'h30000;
			cfg_q.dir_y         <= '0;
			cfg_q.plane_x       <= '0;
			cfg_q.plane_y       <= 18'd43253;
			cfg_q.screen_width  <= 11'd640;
			cfg_q.screen_height <= 11'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grc_pkg::REG_POS_X:    cfg_q.pos_x         <= cfg_data;
				grc_pkg::REG_POS_Y:    cfg_q.pos_y         <= cfg_data;
				grc_pkg::REG_DIR_X:    cfg_q.dir_x         <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::REG_DIR_Y:    cfg_q.dir_y         <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::REG_PLANE_X:  cfg_q.plane_x       <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::REG_PLANE_Y:  cfg_q.plane_y       <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::REG_SCREEN_W: cfg_q.screen_width  <= cfg_data[grc_pkg::SCR_W-1:0];
				grc_pkg::REG_SCREEN_H: cfg_q.screen_height <= cfg_data[grc_pkg::SCR_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	grc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg            (cfg_q),
		.column         (column),
		.cell_row       (cell_row),
		.cell_col       (cell_col),
		.cell_value     (cell_value),
		.done           (done),
		.wall_found     (wall_found),
		.hit_side       (hit_side),
		.hit_row        (hit_row),
		.hit_col        (hit_col),
		.texture_index  (texture_index),
		.perp_distance  (perp_distance),
		.slice_height   (slice_height),
		.draw_start     (draw_start),
		.draw_end       (draw_end),
		.texture_column (texture_column)
	);

endmodule

// ===== rtl/core/grc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/grc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on grc_pkg.
module grc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grc_pkg::NUM_W-1:0]    num,
	input  logic [grc_pkg::DEN_W-1:0]    den,
	output logic                         busy,
	output logic [grc_pkg::NUM_W-1:0]    quot
);

	localparam int CNT_W = $clog2(grc_pkg::NUM_W);

	logic [grc_pkg::NUM_W-1:0] work_q;
	logic [grc_pkg::DEN_W-1:0] rem_q;
	logic [grc_pkg::DEN_W-1:0] den_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic [grc_pkg::DEN_W:0]   rem_sh;
	logic [grc_pkg::DEN_W:0]   rem_sub;
	logic                      ge;

	assign rem_sh  = {rem_q, work_q[grc_pkg::NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(grc_pkg::NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[grc_pkg::NUM_W-2:0], ge};
			rem_q  <= ge ? rem_sub[grc_pkg::DEN_W-1:0] : rem_sh[grc_pkg::DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = work_q;

endmodule

// ===== rtl/core/grc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the ray caster: issues one datapath command per cycle.
// Depends on grc_pkg.
module grc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          req_type,
	input  grc_pkg::sts_t sts,
	output grc_pkg::cmd_t cmd,
	output logic          busy
);

	localparam logic [4:0] ST_CLEAR      = 5'd0;
	localparam logic [4:0] ST_IDLE       = 5'd1;
	localparam logic [4:0] ST_CAM_WAIT   = 5'd2;
	localparam logic [4:0] ST_CAM        = 5'd3;
	localparam logic [4:0] ST_MULX       = 5'd4;
	localparam logic [4:0] ST_MULY       = 5'd5;
	localparam logic [4:0] ST_RDY        = 5'd6;
	localparam logic [4:0] ST_DX_WAIT    = 5'd7;
	localparam logic [4:0] ST_DX         = 5'd8;
	localparam logic [4:0] ST_DY_WAIT    = 5'd9;
	localparam logic [4:0] ST_DY         = 5'd10;
	localparam logic [4:0] ST_SX_LO      = 5'd11;
	localparam logic [4:0] ST_SX_HI      = 5'd12;
	localparam logic [4:0] ST_SY_LO      = 5'd13;
	localparam logic [4:0] ST_SY_HI      = 5'd14;
	localparam logic [4:0] ST_SY_END     = 5'd15;
	localparam logic [4:0] ST_STEP       = 5'd16;
	localparam logic [4:0] ST_CHECK      = 5'd17;
	localparam logic [4:0] ST_PERP       = 5'd18;
	localparam logic [4:0] ST_TEX        = 5'd19;
	localparam logic [4:0] ST_SLICE_WAIT = 5'd20;
	localparam logic [4:0] ST_FINISH     = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = grc_pkg::OP_NOP;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = grc_pkg::OP_CLEAR;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_type) begin
						cmd.op = grc_pkg::OP_MAPWR;
					end else begin
						cmd.op  = grc_pkg::OP_INIT;
						state_d = ST_CAM_WAIT;
					end
				end
			end
			ST_CAM_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_CAM;
				end
			end
			ST_CAM: begin
				cmd.op  = grc_pkg::OP_CAM;
				state_d = ST_MULX;
			end
			ST_MULX: begin
				cmd.op  = grc_pkg::OP_MULX;
				state_d = ST_MULY;
			end
			ST_MULY: begin
				cmd.op  = grc_pkg::OP_MULY;
				state_d = ST_RDY;
			end
			ST_RDY: begin
				cmd.op  = grc_pkg::OP_RDY;
				state_d = ST_DX_WAIT;
			end
			ST_DX_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_DX;
				end
			end
			ST_DX: begin
				cmd.op  = grc_pkg::OP_DX;
				state_d = ST_DY_WAIT;
			end
			ST_DY_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_DY;
				end
			end
			ST_DY: begin
				cmd.op  = grc_pkg::OP_DY;
				state_d = ST_SX_LO;
			end
			ST_SX_LO: begin
				cmd.op  = grc_pkg::OP_SX_LO;
				state_d = ST_SX_HI;
			end
			ST_SX_HI: begin
				cmd.op  = grc_pkg::OP_SX_HI;
				state_d = ST_SY_LO;
			end
			ST_SY_LO: begin
				cmd.op  = grc_pkg::OP_SY_LO;
				state_d = ST_SY_HI;
			end
			ST_SY_HI: begin
				cmd.op  = grc_pkg::OP_SY_HI;
				state_d = ST_SY_END;
			end
			ST_SY_END: begin
				cmd.op  = grc_pkg::OP_SY_END;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.op  = grc_pkg::OP_STEP;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.op  = grc_pkg::OP_CHECK;
				state_d = sts.stop ? ST_PERP : ST_STEP;
			end
			ST_PERP: begin
				cmd.op  = grc_pkg::OP_PERP;
				state_d = ST_TEX;
			end
			ST_TEX: begin
				cmd.op  = grc_pkg::OP_TEX;
				state_d = ST_SLICE_WAIT;
			end
			ST_SLICE_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.op  = grc_pkg::OP_FINISH;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_check_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> $past(state_q) == ST_STEP)
		else $error("map check without a preceding step");

	a_cast_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req_type) |=> busy)
		else $error("cast beat accepted but sequencer stayed idle");

	a_cam_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CAM |-> !sts.div_busy)
		else $error("camera value taken while divider busy");

endmodule

// ===== rtl/core/grc_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the ray caster: ray setup, DDA stepping, distance and span.
// Depends on grc_pkg, grc_div and grc_ram.
module grc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  grc_pkg::cmd_t                  cmd,
	output grc_pkg::sts_t                  sts,
	input  grc_pkg::cfg_t                  cfg,
	input  logic [grc_pkg::COL_W-1:0]      column,
	input  logic [grc_pkg::MAP_BITS-1:0]   cell_row,
	input  logic [grc_pkg::MAP_BITS-1:0]   cell_col,
	input  logic [grc_pkg::CELL_W-1:0]     cell_value,
	output logic                           done,
	output logic                           wall_found,
	output logic                           hit_side,
	output logic [grc_pkg::MAP_BITS-1:0]   hit_row,
	output logic [grc_pkg::MAP_BITS-1:0]   hit_col,
	output logic [2:0]                     texture_index,
	output logic [grc_pkg::PERP_W-1:0]     perp_distance,
	output logic [grc_pkg::HGT_W-1:0]      slice_height,
	output logic [grc_pkg::SPAN_W-1:0]     draw_start,
	output logic [grc_pkg::SPAN_W-1:0]     draw_end,
	output logic [grc_pkg::TEX_W-1:0]      texture_column
);

	localparam int ONE_Q16 = 65536;
	localparam logic signed [grc_pkg::CRD_W-1:0] MAP_LAST =
		grc_pkg::CRD_W'(grc_pkg::MAP_SIZE - 1);

	// sanitised screen size
	logic [grc_pkg::SCR_W-1:0] w_eff;
	logic [grc_pkg::SCR_W-1:0] h_eff;

	assign w_eff = (cfg.screen_width == '0) ? grc_pkg::SCR_W'(1) :
		(cfg.screen_width > grc_pkg::SCR_W'(grc_pkg::MAX_COLUMNS)) ?
		grc_pkg::SCR_W'(grc_pkg::MAX_COLUMNS) : cfg.screen_width;
	assign h_eff = (cfg.screen_height == '0) ? grc_pkg::SCR_W'(1) : cfg.screen_height;

	// registers
	logic signed [grc_pkg::CAM_W-1:0]  cam_q;
	logic signed [grc_pkg::RAY_W-1:0]  rdx_q;
	logic signed [grc_pkg::RAY_W-1:0]  rdy_q;
	logic [grc_pkg::DELTA_W-1:0]       dx_q;
	logic [grc_pkg::DELTA_W-1:0]       dy_q;
	logic [grc_pkg::SD_W-1:0]          sdx_q;
	logic [grc_pkg::SD_W-1:0]          sdy_q;
	logic signed [grc_pkg::CRD_W-1:0]  mx_q;
	logic signed [grc_pkg::CRD_W-1:0]  my_q;
	logic [grc_pkg::STEP_W-1:0]        steps_q;
	logic                              side_q;
	logic                              outside_q;
	logic                              hit_q;
	logic [grc_pkg::CELL_W-1:0]        code_q;
	logic [grc_pkg::PERP_W-1:0]        perp_q;
	logic signed [grc_pkg::PROD_W-1:0] prod_q;
	logic [grc_pkg::ADDR_W-1:0]        clr_q;
	logic                              done_q;

	// shared multiplier
	logic signed [grc_pkg::MUL_W-1:0] mul_a;
	logic signed [grc_pkg::MUL_W-1:0] mul_b;
	logic                             mul_en;
	logic [16:0]                      fxs;
	logic [16:0]                      fys;

	assign fxs = rdx_q[grc_pkg::RAY_W-1] ? {1'b0, cfg.pos_x[15:0]} :
		17'(ONE_Q16) - {1'b0, cfg.pos_x[15:0]};
	assign fys = rdy_q[grc_pkg::RAY_W-1] ? {1'b0, cfg.pos_y[15:0]} :
		17'(ONE_Q16) - {1'b0, cfg.pos_y[15:0]};

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			grc_pkg::OP_MULX: begin
				mul_a = grc_pkg::MUL_W'($signed(cfg.plane_x));
				mul_b = grc_pkg::MUL_W'(cam_q);
			end
			grc_pkg::OP_MULY: begin
				mul_a = grc_pkg::MUL_W'($signed(cfg.plane_y));
				mul_b = grc_pkg::MUL_W'(cam_q);
			end
			grc_pkg::OP_SX_LO: begin
				mul_a = $signed(grc_pkg::MUL_W'(fxs));
				mul_b = $signed(grc_pkg::MUL_W'(dx_q[15:0]));
			end
			grc_pkg::OP_SX_HI: begin
				mul_a = $signed(grc_pkg::MUL_W'(fxs));
				mul_b = $signed(grc_pkg::MUL_W'(dx_q[32:16]));
			end
			grc_pkg::OP_SY_LO: begin
				mul_a = $signed(grc_pkg::MUL_W'(fys));
				mul_b = $signed(grc_pkg::MUL_W'(dy_q[15:0]));
			end
			grc_pkg::OP_SY_HI: begin
				mul_a = $signed(grc_pkg::MUL_W'(fys));
				mul_b = $signed(grc_pkg::MUL_W'(dy_q[32:16]));
			end
			grc_pkg::OP_TEX: begin
				mul_a = $signed(grc_pkg::MUL_W'(perp_q));
				mul_b = grc_pkg::MUL_W'(side_q ? rdx_q : rdy_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// shared divider
	logic                       div_start;
	logic [grc_pkg::NUM_W-1:0]  div_num;
	logic [grc_pkg::DEN_W-1:0]  div_den;
	logic                       div_busy;
	logic [grc_pkg::NUM_W-1:0]  div_q;
	logic [grc_pkg::RAY_W-1:0]  abs_x;
	logic [grc_pkg::RAY_W-1:0]  abs_y;

	assign abs_x = rdx_q[grc_pkg::RAY_W-1] ? -rdx_q : rdx_q;
	assign abs_y = rdy_q[grc_pkg::RAY_W-1] ? -rdy_q : rdy_q;

	always_comb begin
		div_start = 1'b1;
		div_num   = grc_pkg::NUM_W'(1) << 32;
		div_den   = '0;
		case (cmd.op)
			grc_pkg::OP_INIT: begin
				div_num = grc_pkg::NUM_W'({column, 17'b0});
				div_den = grc_pkg::DEN_W'(w_eff);
			end
			grc_pkg::OP_RDY: begin
				div_den = abs_x[grc_pkg::DEN_W-1:0];
			end
			grc_pkg::OP_DX: begin
				div_den = abs_y[grc_pkg::DEN_W-1:0];
			end
			grc_pkg::OP_TEX: begin
				div_num = grc_pkg::NUM_W'({h_eff, 16'b0});
				div_den = grc_pkg::DEN_W'(perp_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_q)
	);

	// map store
	logic                          ram_we;
	logic [grc_pkg::ADDR_W-1:0]    ram_waddr;
	logic [grc_pkg::CELL_W-1:0]    ram_wdata;
	logic [grc_pkg::ADDR_W-1:0]    ram_raddr;
	logic [grc_pkg::CELL_W-1:0]    ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		case (cmd.op)
			grc_pkg::OP_CLEAR: begin
				ram_we = 1'b1;
			end
			grc_pkg::OP_MAPWR: begin
				ram_we    = 1'b1;
				ram_waddr = {cell_row, cell_col};
				ram_wdata = cell_value;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	grc_ram #(
		.WIDTH (grc_pkg::CELL_W),
		.DEPTH (grc_pkg::MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// DDA step candidate
	logic                             xstep;
	logic signed [grc_pkg::CRD_W-1:0] mx_c;
	logic signed [grc_pkg::CRD_W-1:0] my_c;
	logic                             out_c;
	logic [grc_pkg::CELL_W-1:0]       code_c;

	assign xstep = sdx_q < sdy_q;
	assign mx_c  = !xstep ? mx_q :
		(rdx_q[grc_pkg::RAY_W-1] ? mx_q - grc_pkg::CRD_W'(1) : mx_q + grc_pkg::CRD_W'(1));
	assign my_c  = xstep ? my_q :
		(rdy_q[grc_pkg::RAY_W-1] ? my_q - grc_pkg::CRD_W'(1) : my_q + grc_pkg::CRD_W'(1));
	assign out_c = (mx_c < 0) || (mx_c > MAP_LAST) || (my_c < 0) || (my_c > MAP_LAST);
	assign ram_raddr = {mx_c[grc_pkg::MAP_BITS-1:0], my_c[grc_pkg::MAP_BITS-1:0]};
	assign code_c = outside_q ? grc_pkg::CELL_W'(1) : ram_rdata;

	// distance
	logic [grc_pkg::SD_W-1:0] perp_raw;

	assign perp_raw = side_q ? sdy_q - grc_pkg::SD_W'(dy_q) : sdx_q - grc_pkg::SD_W'(dx_q);

	// finishing arithmetic
	logic [grc_pkg::HGT_W-1:0]  slice;
	logic [grc_pkg::SPAN_W-1:0] h_half;
	logic [grc_pkg::SPAN_W-1:0] s_half;
	logic [grc_pkg::SPAN_W-1:0] ds;
	logic [grc_pkg::SCR_W-1:0]  de_sum;
	logic [grc_pkg::SCR_W-1:0]  de_clip;
	logic [grc_pkg::SPAN_W-1:0] de;
	logic [15:0]                frac;
	logic [grc_pkg::TEX_W-1:0]  texx;
	logic                       mirror;

	assign slice   = (div_q > grc_pkg::NUM_W'(2047)) ? grc_pkg::HGT_W'(2047) :
		div_q[grc_pkg::HGT_W-1:0];
	assign h_half  = h_eff[grc_pkg::SCR_W-1:1];
	assign s_half  = slice[grc_pkg::HGT_W-1:1];
	assign ds      = (h_half >= s_half) ? h_half - s_half : '0;
	assign de_sum  = {1'b0, s_half} + {1'b0, h_half};
	assign de_clip = (de_sum >= h_eff) ? h_eff - grc_pkg::SCR_W'(1) : de_sum;
	assign de      = (de_clip > grc_pkg::SCR_W'(1023)) ? grc_pkg::SPAN_W'(1023) :
		de_clip[grc_pkg::SPAN_W-1:0];
	assign frac    = (side_q ? cfg.pos_x[15:0] : cfg.pos_y[15:0]) + prod_q[31:16];
	assign texx    = frac[15 -: grc_pkg::TEX_W];
	// mirrored on an x side facing +x, or a y side facing -y
	assign mirror  = (!side_q && !rdx_q[grc_pkg::RAY_W-1] && (rdx_q != '0)) ||
		(side_q && rdy_q[grc_pkg::RAY_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == grc_pkg::OP_FINISH);
			if (cmd.op == grc_pkg::OP_CLEAR) begin
				clr_q <= clr_q + grc_pkg::ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			grc_pkg::OP_INIT: begin
				mx_q    <= grc_pkg::CRD_W'(cfg.pos_x[grc_pkg::POS_W-1:16]);
				my_q    <= grc_pkg::CRD_W'(cfg.pos_y[grc_pkg::POS_W-1:16]);
				steps_q <= '0;
				side_q  <= 1'b0;
				hit_q   <= 1'b0;
				code_q  <= '0;
			end
			grc_pkg::OP_CAM: begin
				cam_q <= $signed({1'b0, div_q[grc_pkg::CAM_W-2:0]}) -
					$signed(grc_pkg::CAM_W'(ONE_Q16));
			end
			grc_pkg::OP_MULY: begin
				rdx_q <= grc_pkg::RAY_W'($signed(cfg.dir_x)) + $signed(prod_q[45:16]);
			end
			grc_pkg::OP_RDY: begin
				rdy_q <= grc_pkg::RAY_W'($signed(cfg.dir_y)) + $signed(prod_q[45:16]);
			end
			grc_pkg::OP_DX: begin
				dx_q <= (rdx_q == '0) ? grc_pkg::DELTA_INF : grc_pkg::DELTA_W'(div_q);
			end
			grc_pkg::OP_DY: begin
				dy_q <= (rdy_q == '0) ? grc_pkg::DELTA_INF : grc_pkg::DELTA_W'(div_q);
			end
			grc_pkg::OP_SX_HI: begin
				sdx_q <= grc_pkg::SD_W'(prod_q[grc_pkg::PROD_W-1:16]);
			end
			grc_pkg::OP_SY_LO: begin
				sdx_q <= (rdx_q == '0) ? grc_pkg::SD_W'({fxs, 24'b0}) :
					sdx_q + prod_q[grc_pkg::SD_W-1:0];
			end
			grc_pkg::OP_SY_HI: begin
				sdy_q <= grc_pkg::SD_W'(prod_q[grc_pkg::PROD_W-1:16]);
			end
			grc_pkg::OP_SY_END: begin
				sdy_q <= (rdy_q == '0) ? grc_pkg::SD_W'({fys, 24'b0}) :
					sdy_q + prod_q[grc_pkg::SD_W-1:0];
			end
			grc_pkg::OP_STEP: begin
				if (xstep) begin
					sdx_q <= sdx_q + grc_pkg::SD_W'(dx_q);
				end else begin
					sdy_q <= sdy_q + grc_pkg::SD_W'(dy_q);
				end
				mx_q      <= mx_c;
				my_q      <= my_c;
				side_q    <= !xstep;
				outside_q <= out_c;
				steps_q   <= steps_q + grc_pkg::STEP_W'(1);
			end
			grc_pkg::OP_CHECK: begin
				hit_q  <= (code_c != '0);
				code_q <= code_c;
			end
			grc_pkg::OP_PERP: begin
				perp_q <= (perp_raw > grc_pkg::SD_W'(24'hFFFFFF)) ? 24'hFFFFFF :
					perp_raw[grc_pkg::PERP_W-1:0];
			end
			grc_pkg::OP_FINISH: begin
				wall_found     <= hit_q;
				hit_side       <= side_q;
				hit_row        <= mx_q[grc_pkg::MAP_BITS-1:0];
				hit_col        <= my_q[grc_pkg::MAP_BITS-1:0];
				texture_index  <= hit_q ? code_q - 3'd1 : 3'd0;
				perp_distance  <= perp_q;
				slice_height   <= slice;
				draw_start     <= ds;
				draw_end       <= de;
				texture_column <= mirror ? ~texx : texx;
			end
			default: begin
				steps_q <= steps_q;
			end
		endcase
	end

	assign sts.div_busy = div_busy;
	assign sts.stop     = (code_c != '0) || (steps_q == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS));
	assign sts.clr_last = &clr_q;
	assign done         = done_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_ray_caster_column_core: map writes, casts, register writes.
// Depends on grc_pkg and the core RTL; predicts every cast result with a fixed-point DDA tracer.

module testbench;
	import grc_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int IDLE_LIMIT  = 6000;	// clear pass plus a worst cast, many times over
	localparam int DRAIN_WAIT  = 400;	// longer than the slowest cast
	localparam int N_RANDOM    = 1720;
	localparam int N_SCENES    = 12;
	localparam int REQ_CAST    = 0;
	localparam int REQ_MAPWR   = 1;
	// indices past the register list
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 4'd8;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 4'd15;

	typedef struct {
		logic                 wall_found;
		logic                 hit_side;
		logic [MAP_BITS-1:0]  hit_row;
		logic [MAP_BITS-1:0]  hit_col;
		logic [2:0]           texture_index;
		logic [PERP_W-1:0]    perp_distance;
		logic [HGT_W-1:0]     slice_height;
		logic [SPAN_W-1:0]    draw_start;
		logic [SPAN_W-1:0]    draw_end;
		logic [TEX_W-1:0]     texture_column;
	} ray_hit_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic start;
	logic busy;
	logic req_type;
	logic [COL_W-1:0] column;
	logic [MAP_BITS-1:0] cell_row;
	logic [MAP_BITS-1:0] cell_col;
	logic [CELL_W-1:0] cell_value;
	logic done;
	logic wall_found;
	logic hit_side;
	logic [MAP_BITS-1:0] hit_row;
	logic [MAP_BITS-1:0] hit_col;
	logic [2:0] texture_index;
	logic [PERP_W-1:0] perp_distance;
	logic [HGT_W-1:0] slice_height;
	logic [SPAN_W-1:0] draw_start;
	logic [SPAN_W-1:0] draw_end;
	logic [TEX_W-1:0] texture_column;

	// shadow copy of the camera registers and the map
	logic [POS_W-1:0] cam_pos_x, cam_pos_y;
	logic [VEC_W-1:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
	logic [SCR_W-1:0] scr_width, scr_height;
	logic [CELL_W-1:0] map_copy [MAP_DEPTH];

	ray_hit_t pending_hits[$];
	int error_count;
	int casts_sent, writes_sent, hits_checked, walls_seen;
	int idle_cycles;
	bit no_gaps;

	grid_ray_caster_column_core u_top (.*);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// DDA trace of one column from the shadow state
	function automatic ray_hit_t trace_column(logic [COL_W-1:0] col);
		ray_hit_t r;
		longint w, h, cam, rdx, rdy, mx, my, fx, fy, dx, dy, sdx, sdy;
		longint perp, slice, ds, de, t, texx;
		int steps;
		int code;
		bit hit, side;
		w = (scr_width == 0) ? 1 : longint'(scr_width);
		if (w > MAX_COLUMNS)
			w = MAX_COLUMNS;
		h = (scr_height == 0) ? 1 : longint'(scr_height);
		cam = (2 * longint'(col) * 65536) / w - 65536;
		rdx = longint'($signed(cam_dir_x)) + ((longint'($signed(cam_plane_x)) * cam) >>> 16);
		rdy = longint'($signed(cam_dir_y)) + ((longint'($signed(cam_plane_y)) * cam) >>> 16);
		mx = longint'(cam_pos_x) >> 16;
		my = longint'(cam_pos_y) >> 16;
		fx = longint'(cam_pos_x) & 'hFFFF;
		fy = longint'(cam_pos_y) & 'hFFFF;
		dx = (rdx == 0) ? (64'd1 << 40) : (64'd1 << 32) / (rdx < 0 ? -rdx : rdx);
		dy = (rdy == 0) ? (64'd1 << 40) : (64'd1 << 32) / (rdy < 0 ? -rdy : rdy);
		sdx = ((rdx < 0 ? fx : 65536 - fx) * dx) >> 16;
		sdy = ((rdy < 0 ? fy : 65536 - fy) * dy) >> 16;
		steps = 0;
		hit = 1'b0;
		side = 1'b0;
		code = 0;
		while (!hit && steps < MAX_STEPS) begin
			// tie goes to the y axis
			if (sdx < sdy) begin
				sdx += dx;
				mx += (rdx < 0) ? -1 : 1;
				side = 1'b0;
			end else begin
				sdy += dy;
				my += (rdy < 0) ? -1 : 1;
				side = 1'b1;
			end
			if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE)
				code = 1;	// outside the map is a plain wall
			else
				code = map_copy[mx * MAP_SIZE + my];
			hit = (code != 0);
			steps++;
		end
		perp = side ? sdy - dy : sdx - dx;
		if (perp > 'hFFFFFF)
			perp = 'hFFFFFF;
		if (perp == 0)
			slice = 2047;
		else begin
			slice = (h << 16) / perp;
			if (slice > 2047)
				slice = 2047;
		end
		ds = h / 2 - slice / 2;
		if (ds < 0)
			ds = 0;
		de = slice / 2 + h / 2;
		if (de >= h)
			de = h - 1;
		if (de > 1023)
			de = 1023;
		if (side == 0)
			t = longint'(cam_pos_y) + ((perp * rdy) >>> 16);
		else
			t = longint'(cam_pos_x) + ((perp * rdx) >>> 16);
		texx = ((t & 'hFFFF) * TEX_SIZE) >> 16;
		if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
			texx = TEX_SIZE - texx - 1;
		r.wall_found     = hit;
		r.hit_side       = side;
		r.hit_row        = mx[MAP_BITS-1:0];
		r.hit_col        = my[MAP_BITS-1:0];
		r.texture_index  = hit ? 3'(code - 1) : 3'd0;
		r.perp_distance  = perp[PERP_W-1:0];
		r.slice_height   = slice[HGT_W-1:0];
		r.draw_start     = ds[SPAN_W-1:0];
		r.draw_end       = de[SPAN_W-1:0];
		r.texture_column = texx[TEX_W-1:0];
		return r;
	endfunction

	// one beat on the command port; leaves start high at a falling edge
	task automatic send_beat(bit kind, logic [COL_W-1:0] col, logic [MAP_BITS-1:0] row,
			logic [MAP_BITS-1:0] ccol, logic [CELL_W-1:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type   = kind;
		column     = col;
		cell_row   = row;
		cell_col   = ccol;
		cell_value = val;
		start      = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// accepted at this edge
		if (kind == REQ_MAPWR) begin
			map_copy[row * MAP_SIZE + ccol] = val;
			writes_sent++;
		end else begin
			pending_hits.push_back(trace_column(col));
			casts_sent++;
		end
		@(negedge clk);
	endtask

	task automatic cast_column(logic [COL_W-1:0] col);
		send_beat(1'(REQ_CAST), col, MAP_BITS'($urandom), MAP_BITS'($urandom),
			CELL_W'($urandom));
	endtask

	task automatic put_cell(int row, int ccol, int val);
		send_beat(1'(REQ_MAPWR), COL_W'($urandom), MAP_BITS'(row), MAP_BITS'(ccol),
			CELL_W'(val));
	endtask

	// registers only move once every cast has reported and the core has settled
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		start = 1'b0;
		while (pending_hits.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_POS_X:    cam_pos_x   = data[POS_W-1:0];
			REG_POS_Y:    cam_pos_y   = data[POS_W-1:0];
			REG_DIR_X:    cam_dir_x   = data[VEC_W-1:0];
			REG_DIR_Y:    cam_dir_y   = data[VEC_W-1:0];
			REG_PLANE_X:  cam_plane_x = data[VEC_W-1:0];
			REG_PLANE_Y:  cam_plane_y = data[VEC_W-1:0];
			REG_SCREEN_W: scr_width   = data[SCR_W-1:0];
			REG_SCREEN_H: scr_height  = data[SCR_W-1:0];
			default: ;	// unused index, no effect
		endcase
	endtask

	// reset camera, corners of the map and every cell code
	task automatic test_default_camera;
		no_gaps = 1'b0;
		cast_column(COL_W'(0));
		cast_column(COL_W'(1023));
		put_cell(0, 0, 7);
		put_cell(31, 31, 1);
		put_cell(0, 31, 3);
		put_cell(31, 0, 5);
		for (int v = 1; v <= 6; v++)
			put_cell(1, v, v);
		put_cell(0, 0, 0);	// clear back to empty
		cast_column(COL_W'(320));
		cast_column(COL_W'(639));
		cast_column(COL_W'(640));	// past the screen edge, camera extrapolated
	endtask

	// camera right on a boundary next to a wall, zero ray components, odd screen sizes
	task automatic test_camera_corners;
		write_reg(REG_POS_X, 21'(5 << 16));
		write_reg(REG_POS_Y, 21'((5 << 16) + 'h8000));
		put_cell(4, 5, 2);
		cast_column(COL_W'(320));	// zero distance, height saturates
		write_reg(REG_PLANE_Y, '0);
		cast_column(COL_W'(17));	// y component zero: ray never moves in y
		write_reg(REG_DIR_X, '0);
		write_reg(REG_DIR_Y, 21'(65536));
		cast_column(COL_W'(900));	// x component zero
		write_reg(REG_SCREEN_W, '0);
		write_reg(REG_SCREEN_H, '0);
		cast_column(COL_W'(0));
		cast_column(COL_W'(1));
		write_reg(REG_SCREEN_W, 21'(2047));
		write_reg(REG_SCREEN_H, 21'(2047));
		cast_column(COL_W'(1023));
		write_reg(REG_SPARE_LO, 21'h1FFFFF);
		write_reg(REG_SPARE_HI, 21'h0A5A5A);
		cast_column(COL_W'(511));
	endtask

	task automatic load_scene(int scene);
		if (scene == 0) begin
			// largest positive extremes
			write_reg(REG_POS_X, 21'h1FFFFF);
			write_reg(REG_POS_Y, 21'h1FFFFF);
			write_reg(REG_DIR_X, 21'h1FFFF);
			write_reg(REG_DIR_Y, 21'h1FFFF);
			write_reg(REG_PLANE_X, 21'h1FFFF);
			write_reg(REG_PLANE_Y, 21'h1FFFF);
			write_reg(REG_SCREEN_W, 21'd1024);
			write_reg(REG_SCREEN_H, 21'd1024);
		end else if (scene == 1) begin
			// most negative vectors, tiny screen
			write_reg(REG_POS_X, '0);
			write_reg(REG_POS_Y, '0);
			write_reg(REG_DIR_X, 21'h20000);
			write_reg(REG_DIR_Y, 21'h20000);
			write_reg(REG_PLANE_X, 21'h20000);
			write_reg(REG_PLANE_Y, 21'h20000);
			write_reg(REG_SCREEN_W, 21'd1);
			write_reg(REG_SCREEN_H, 21'd1);
		end else begin
			write_reg(REG_POS_X, 21'($urandom));
			write_reg(REG_POS_Y, 21'($urandom));
			write_reg(REG_DIR_X, 21'($urandom));
			write_reg(REG_DIR_Y, 21'($urandom));
			write_reg(REG_PLANE_X, 21'($urandom_range(0, 3) == 0 ? 0 : $urandom));
			write_reg(REG_PLANE_Y, 21'($urandom));
			write_reg(REG_SCREEN_W, 21'($urandom_range(0, 2047)));
			write_reg(REG_SCREEN_H, 21'($urandom_range(0, 2047)));
		end
	endtask

	// fixed then random scenes: fresh camera, a streak of map writes, then mixed casts and writes
	task automatic test_random_scenes;
		int per_scene;
		per_scene = N_RANDOM / N_SCENES;
		for (int s = 0; s < N_SCENES; s++) begin
			load_scene(s);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < per_scene; i++) begin
				if (i % 40 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				if (i < 20 || $urandom_range(0, 9) < 4)
					put_cell($urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 7));
				else
					cast_column(COL_W'($urandom));
			end
		end
	endtask

	// each strobed result against the oldest prediction
	always @(posedge clk) begin
		ray_hit_t e;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$error("result with no cast outstanding");
				error_count++;
			end else begin
				e = pending_hits.pop_front();
				hits_checked++;
				if (e.wall_found)
					walls_seen++;
				if (wall_found !== e.wall_found) begin
					$error("wall_found exp %0d got %0d", e.wall_found, wall_found);
					error_count++;
				end
				if (hit_side !== e.hit_side) begin
					$error("hit_side exp %0d got %0d", e.hit_side, hit_side);
					error_count++;
				end
				if (hit_row !== e.hit_row) begin
					$error("hit_row exp %0d got %0d", e.hit_row, hit_row);
					error_count++;
				end
				if (hit_col !== e.hit_col) begin
					$error("hit_col exp %0d got %0d", e.hit_col, hit_col);
					error_count++;
				end
				if (texture_index !== e.texture_index) begin
					$error("texture_index exp %0d got %0d", e.texture_index, texture_index);
					error_count++;
				end
				if (perp_distance !== e.perp_distance) begin
					$error("perp_distance exp %0h got %0h", e.perp_distance, perp_distance);
					error_count++;
				end
				if (slice_height !== e.slice_height) begin
					$error("slice_height exp %0d got %0d", e.slice_height, slice_height);
					error_count++;
				end
				if (draw_start !== e.draw_start) begin
					$error("draw_start exp %0d got %0d", e.draw_start, draw_start);
					error_count++;
				end
				if (draw_end !== e.draw_end) begin
					$error("draw_end exp %0d got %0d", e.draw_end, draw_end);
					error_count++;
				end
				if (texture_column !== e.texture_column) begin
					$error("texture_column exp %0d got %0d", e.texture_column, texture_column);
					error_count++;
				end
			end
		end
	end

	// watchdog: cycles with neither a beat taken nor a result shown
	always @(posedge clk) begin
		if (done || (start && !busy))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		req_type = 1'b0;
		column = '0;
		cell_row = '0;
		cell_col = '0;
		cell_value = '0;
		error_count = 0;
		casts_sent = 0;
		writes_sent = 0;
		hits_checked = 0;
		walls_seen = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		cam_pos_x = '0;
		cam_pos_y = '0;
		cam_dir_x = VEC_W'(-65536);
		cam_dir_y = '0;
		cam_plane_x = '0;
		cam_plane_y = VEC_W'(43253);
		scr_width = SCR_W'(640);
		scr_height = SCR_W'(480);
		foreach (map_copy[i])
			map_copy[i] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_default_camera();
		test_camera_corners();
		test_random_scenes();

		start = 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Covered %0d casts (%0d hit a wall) and %0d map writes over %0d camera scenes",
			hits_checked, walls_seen, writes_sent, N_SCENES + 2);
		if (error_count == 0 && pending_hits.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== grid_ray_caster_column_core.f =====
rtl/core/grc_pkg.sv
rtl/core/grc_ram.sv
rtl/core/grc_div.sv
rtl/core/grc_ctrl.sv
rtl/core/grc_dp.sv
rtl/core/grid_ray_caster_column_core.sv
verif/testbench.sv
